[rtl/mdcf_pkg.sv]
// Shared types, constants and CRC helper for the drive command framer.
// No dependencies; used by every module of the block.
package mdcf_pkg;

  // Configuration register indexes and reset values
  localparam logic [1:0]  CFG_STATION     = 2'd0;
  localparam logic [1:0]  CFG_SPEED_REG   = 2'd1;
  localparam logic [1:0]  CFG_COMMAND_REG = 2'd2;
  localparam int          CFG_INDEX_W     = 2;
  localparam int          CFG_DATA_W      = 16;
  localparam logic [7:0]  STATION_RESET   = 8'd1;
  localparam logic [15:0] SPEED_REG_RESET = 16'd258;
  localparam logic [15:0] CMD_REG_RESET   = 16'd257;

  // Frame constants
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;

  // Divide by 3: q = (x * 43691) >> 17, exact for 16-bit x
  localparam logic [16:0] DIV3_RECIP = 17'd43691;
  localparam int          DIV3_SHIFT = 17;

  // Frame queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // One frame to be sent by the back end
  typedef struct packed {
    logic [7:0]  station;
    logic [15:0] reg_addr;
    logic [15:0] value;
    logic        last;
  } frame_t;

  // Feed one byte into a reflected CRC-16
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/mdcf_if.sv]
// Valid/ready channel interfaces for commands, output bytes and config writes.
// Depends on mdcf_pkg for the config index and data widths.
interface mdcf_cmd_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        direction;
  logic [15:0] speed;
  modport source (output valid, action, direction, speed, input ready);
  modport sink (input valid, action, direction, speed, output ready);
endinterface

interface mdcf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       end_of_frame;
  logic       last;
  modport source (output valid, tx_byte, end_of_frame, last, input ready);
  modport sink (input valid, tx_byte, end_of_frame, last, output ready);
endinterface

interface mdcf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mdcf_pkg::CFG_INDEX_W-1:0] index;
  logic [mdcf_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/mdcf_front.sv]
// Front end: holds config registers, accepts commands, scales the speed and
// pushes one or two frame descriptors into the queue. Depends on mdcf_pkg, mdcf_if.
module mdcf_front (
  input  logic             clk,
  input  logic             rst,
  mdcf_cmd_if.sink         cmd,
  mdcf_cfg_if.sink         cfg,
  output logic             push_valid,
  input  logic             push_ready,
  output mdcf_pkg::frame_t push_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SPEED = 2'd1;
  localparam logic [1:0] ST_CMD   = 2'd2;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic [7:0]  station;
  logic [15:0] speed_reg;
  logic [15:0] command_reg;
  logic        act;
  logic        dir;
  logic [15:0] spd;
  logic [15:0] scaled10;
  logic [32:0] product;
  logic [15:0] quotient;
  logic [1:0]  code;

  assign cmd.ready  = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign push_valid = (state != ST_IDLE);

  // Speed scaling: wrap(speed * 10) / 3
  assign scaled10 = {spd[12:0], 3'b000} + {spd[14:0], 1'b0};
  assign product  = {17'd0, scaled10} * {16'd0, mdcf_pkg::DIV3_RECIP};
  assign quotient = product[mdcf_pkg::DIV3_SHIFT +: 16];

  // Run/stop code: bit 1 reverse, bit 0 running
  assign code = {dir, ~act};

  // Descriptor for the frame in progress
  always_comb begin
    push_data.station  = station;
    push_data.reg_addr = (state == ST_SPEED) ? speed_reg : command_reg;
    push_data.value    = (state == ST_SPEED) ? quotient : {14'd0, code};
    push_data.last     = (state == ST_CMD);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = cmd.action ? ST_CMD : ST_SPEED;
        end
      end
      ST_SPEED: begin
        if (push_ready) begin
          state_next = ST_CMD;
        end
      end
      ST_CMD: begin
        if (push_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      station     <= mdcf_pkg::STATION_RESET;
      speed_reg   <= mdcf_pkg::SPEED_REG_RESET;
      command_reg <= mdcf_pkg::CMD_REG_RESET;
    end else begin
      state <= state_next;
      // Config writes; unknown indexes are dropped
      if (cfg.valid) begin
        case (cfg.index)
          mdcf_pkg::CFG_STATION:     station     <= cfg.data[7:0];
          mdcf_pkg::CFG_SPEED_REG:   speed_reg   <= cfg.data;
          mdcf_pkg::CFG_COMMAND_REG: command_reg <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  // Command payload capture
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      act <= cmd.action;
      dir <= cmd.direction;
      spd <= cmd.speed;
    end
  end

endmodule

[rtl/mdcf_queue.sv]
// Small show-ahead queue of frame descriptors between front and back ends.
// Depends on mdcf_pkg for the descriptor type.
module mdcf_queue #(
  parameter int DEPTH = mdcf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  mdcf_pkg::frame_t push_data,
  output logic             pop_valid,
  input  logic             pop,
  output mdcf_pkg::frame_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mdcf_pkg::frame_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/mdcf_back.sv]
// Back end: serializes one frame descriptor into eight bytes with CRC-16,
// one byte per beat through an output register. Depends on mdcf_pkg, mdcf_if.
module mdcf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  input  mdcf_pkg::frame_t frame,
  output logic             frame_pop,
  mdcf_byte_if.source      tx
);

  localparam logic [2:0] POS_CRC_LO = 3'd6;
  localparam logic [2:0] POS_CRC_HI = 3'd7;

  logic [2:0]  pos;
  logic [15:0] crc;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_eof;
  logic        out_last;
  logic        load;
  logic [7:0]  next_byte;

  assign load      = frame_valid && (!out_valid || tx.ready);
  assign frame_pop = load && (pos == POS_CRC_HI);

  assign tx.valid        = out_valid;
  assign tx.tx_byte      = out_byte;
  assign tx.end_of_frame = out_eof;
  assign tx.last         = out_last;

  // Byte selection by position in the frame
  always_comb begin
    unique case (pos)
      3'd0:       next_byte = frame.station;
      3'd1:       next_byte = mdcf_pkg::FUNC_WRITE_SINGLE;
      3'd2:       next_byte = frame.reg_addr[15:8];
      3'd3:       next_byte = frame.reg_addr[7:0];
      3'd4:       next_byte = frame.value[15:8];
      3'd5:       next_byte = frame.value[7:0];
      POS_CRC_LO: next_byte = crc[7:0];
      POS_CRC_HI: next_byte = crc[15:8];
      default:    next_byte = crc[15:8];
    endcase
  end

  // Position, CRC and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      crc       <= mdcf_pkg::CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= pos + 1'b1;
        if (pos == POS_CRC_HI) begin
          crc <= mdcf_pkg::CRC_INIT;
        end else if (pos != POS_CRC_LO) begin
          crc <= mdcf_pkg::crc_feed(crc, next_byte);
        end
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= next_byte;
      out_eof  <= (pos == POS_CRC_HI);
      out_last <= (pos == POS_CRC_HI) && frame.last;
    end
  end

endmodule

[rtl/modbus_drive_command_framer_top.sv]
// Modbus RTU drive command framer: top level wiring front, queue and back.
// Depends on mdcf_pkg, mdcf_if, mdcf_front, mdcf_queue, mdcf_back.
//
// Each accepted command becomes Modbus function-6 frames, one byte per beat:
// a run command gives 16 bytes (scaled speed frame, then run code frame), a
// stop command gives 8 bytes (stop code frame). The serializer in the back end
// sends one byte per cycle while the output is taken; the front end accepts the
// next command once it has queued the frames of the current one, so it overlaps
// the sending of earlier frames. end_of_frame marks each second CRC byte and last
// marks the final byte of a command. Config writes are always accepted and must
// be done while no command is in flight.
module modbus_drive_command_framer_top #(
  parameter int QUEUE_DEPTH = mdcf_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  mdcf_cmd_if.sink    cmd,
  mdcf_cfg_if.sink    cfg,
  mdcf_byte_if.source tx
);

  logic             push_valid;
  logic             push_ready;
  mdcf_pkg::frame_t push_data;
  logic             frame_valid;
  logic             frame_pop;
  mdcf_pkg::frame_t frame;

  mdcf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mdcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (frame_valid),
    .pop        (frame_pop),
    .pop_data   (frame)
  );

  mdcf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_pop   (frame_pop),
    .tx          (tx)
  );

endmodule

[tb/tb_modbus_drive_command_framer_top.sv]
// Testbench for the Modbus drive command framer: drives commands and register
// writes, predicts every frame byte with its CRC and checks the byte stream.
// Depends on rtl/mdcf_pkg.sv, rtl/mdcf_if.sv and the framer RTL.
module tb_modbus_drive_command_framer_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Command field codes
  localparam logic ACT_RUN  = 1'b0;
  localparam logic ACT_STOP = 1'b1;
  localparam logic DIR_FWD  = 1'b0;
  localparam logic DIR_REV  = 1'b1;

  // Drive run/stop codes written to the command register
  localparam logic [1:0] CODE_STOP_FWD = 2'd0;
  localparam logic [1:0] CODE_RUN_FWD  = 2'd1;
  localparam logic [1:0] CODE_STOP_REV = 2'd2;
  localparam logic [1:0] CODE_RUN_REV  = 2'd3;

  // Register index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 40;
  localparam int RAND_PHASES  = 4;
  localparam int PHASE_ITEMS  = 19;

  // One command; known marks a row whose speed word is typed in
  typedef struct packed {
    logic        action;
    logic        dir;
    logic [15:0] speed;
    logic        known;
    logic [15:0] word;
  } cmd_row_t;

  // One byte on the serial side
  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       fin;
  } line_byte_t;

  logic clk;
  logic rst;

  mdcf_cmd_if  cmd_ch ();
  mdcf_cfg_if  cfg_ch ();
  mdcf_byte_if tx_ch ();

  modbus_drive_command_framer_top uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .cfg (cfg_ch),
    .tx  (tx_ch)
  );

  // Shadow registers of the framer
  logic [7:0]  station_addr;
  logic [15:0] speed_reg_addr;
  logic [15:0] cmd_reg_addr;

  line_byte_t line_bytes_q[$];
  line_byte_t want;
  int         errors;
  int         bytes_seen;
  int         quiet_cycles;
  int         stall_left;
  bit         idle_on;

  // Extremes of speed and of the x10 wrap; the run rows carry their typed-in speed word
  cmd_row_t directed_rows [0:7] = '{
    '{ACT_RUN,  DIR_FWD, 16'd0,     1'b1, 16'd0},
    '{ACT_RUN,  DIR_REV, 16'd65535, 1'b1, 16'd21842},
    '{ACT_STOP, DIR_FWD, 16'd0,     1'b0, 16'd0},
    '{ACT_STOP, DIR_REV, 16'd65535, 1'b0, 16'd0},
    '{ACT_RUN,  DIR_FWD, 16'd6553,  1'b1, 16'd21843},
    '{ACT_RUN,  DIR_REV, 16'd6554,  1'b1, 16'd1},
    '{ACT_RUN,  DIR_FWD, 16'h5555,  1'b1, 16'd7280},
    '{ACT_RUN,  DIR_REV, 16'hAAAA,  1'b1, 16'd14561}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch at byte %0d: %s", $realtime, bytes_seen, what);
    errors++;
  endtask

  // Reflected CRC-16, one data bit at a time
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ mdcf_pkg::CRC_POLY;
      end
    end
    return crc;
  endfunction

  // Queue the eight bytes of one write-single-register frame
  task automatic queue_frame(input logic [15:0] addr, input logic [15:0] value,
                             input logic closing);
    logic [7:0]  body [0:5];
    logic [15:0] crc;
    body = '{station_addr, mdcf_pkg::FUNC_WRITE_SINGLE, addr[15:8], addr[7:0],
             value[15:8], value[7:0]};
    crc  = mdcf_pkg::CRC_INIT;
    for (int k = 0; k < 6; k++) begin
      crc = crc16_step(crc, body[k]);
      line_bytes_q.push_back('{body[k], 1'b0, 1'b0});
    end
    line_bytes_q.push_back('{crc[7:0], 1'b0, 1'b0});
    line_bytes_q.push_back('{crc[15:8], 1'b1, closing});
  endtask

  // Expected bytes of one accepted command
  task automatic predict_frames(input cmd_row_t row);
    logic [15:0] tenfold;
    logic [15:0] word;
    tenfold = row.speed * 16'd10;
    word    = row.known ? row.word : tenfold / 16'd3;
    if (row.action == ACT_RUN) begin
      queue_frame(speed_reg_addr, word, 1'b0);
      queue_frame(cmd_reg_addr, {14'd0, row.dir ? CODE_RUN_REV : CODE_RUN_FWD}, 1'b1);
    end else begin
      queue_frame(cmd_reg_addr, {14'd0, row.dir ? CODE_STOP_REV : CODE_STOP_FWD}, 1'b1);
    end
  endtask

  // Send one command; valid stays high afterwards unless a gap follows
  task automatic send_command(input cmd_row_t row);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.action    <= row.action;
    cmd_ch.direction <= row.dir;
    cmd_ch.speed     <= row.speed;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predict_frames(row);
  endtask

  // One register write beat; caller lowers valid after the last one
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      mdcf_pkg::CFG_STATION:     station_addr   = value[7:0];
      mdcf_pkg::CFG_SPEED_REG:   speed_reg_addr = value;
      mdcf_pkg::CFG_COMMAND_REG: cmd_reg_addr   = value;
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [15:0] station_data, input logic [15:0] speed_addr,
                               input logic [15:0] cmd_addr, input logic [15:0] junk);
    write_reg(mdcf_pkg::CFG_COMMAND_REG, cmd_addr);
    write_reg(CFG_UNUSED, junk);
    write_reg(mdcf_pkg::CFG_STATION, station_data);
    write_reg(mdcf_pkg::CFG_SPEED_REG, speed_addr);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every expected byte has come out
  task automatic drain_bytes();
    do @(posedge clk); while (line_bytes_q.size() != 0);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_row_t random_row();
    cmd_row_t row;
    row.action = 1'($urandom_range(0, 1));
    row.dir    = 1'($urandom_range(0, 1));
    row.known  = 1'b0;
    row.word   = 16'd0;
    case ($urandom_range(0, 5))
      0: row.speed = 16'd0;
      1: row.speed = 16'hFFFF;
      // around the points where speed x10 wraps
      2: row.speed = 16'(6553 * $urandom_range(1, 9) + $urandom_range(0, 8));
      default: row.speed = 16'($urandom);
    endcase
    return row;
  endfunction

  // Output side: check each byte beat, then drive ready with stall bursts
  always @(posedge clk) begin
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      if (line_bytes_q.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing expected", tx_ch.tx_byte));
      end else begin
        want = line_bytes_q.pop_front();
        if (tx_ch.tx_byte !== want.data)
          report_mismatch($sformatf("tx_byte %02h, want %02h", tx_ch.tx_byte, want.data));
        if (tx_ch.end_of_frame !== want.eof)
          report_mismatch($sformatf("end_of_frame %b, want %b", tx_ch.end_of_frame, want.eof));
        if (tx_ch.last !== want.fin)
          report_mismatch($sformatf("last %b, want %b", tx_ch.last, want.fin));
      end
      bytes_seen++;
    end
    if (stall_left > 0) begin
      tx_ch.ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      tx_ch.ready <= 1'b0;
      stall_left  <= $urandom_range(0, 11);
    end else begin
      tx_ch.ready <= 1'b1;
    end
  end

  // Watchdog: too long with no beat on any channel
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (tx_ch.valid && tx_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** modbus_drive_command_framer_top: FAILED **");
      $finish;
    end
  end

  // Stimulus
  initial begin
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.action    = ACT_RUN;
    cmd_ch.direction = DIR_FWD;
    cmd_ch.speed     = 16'd0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = mdcf_pkg::CFG_STATION;
    cfg_ch.data      = 16'd0;
    tx_ch.ready      = 1'b0;
    station_addr     = mdcf_pkg::STATION_RESET;
    speed_reg_addr   = mdcf_pkg::SPEED_REG_RESET;
    cmd_reg_addr     = mdcf_pkg::CMD_REG_RESET;
    errors           = 0;
    bytes_seen       = 0;
    quiet_cycles     = 0;
    stall_left       = 0;
    idle_on          = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: table under reset values, all-zero and all-one registers
    for (int pass = 0; pass < 3; pass++) begin
      if (pass == 1) begin
        set_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      end else if (pass == 2) begin
        // upper bits of the station write are dropped
        set_registers(16'hA5FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end
      foreach (directed_rows[r]) begin
        send_command(directed_rows[r]);
      end
      cmd_ch.valid <= 1'b0;
      drain_bytes();
    end

    // Random phases, each with new register values; the last one runs flat out
    for (int p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p != RAND_PHASES - 1);
      set_registers(pick_word(), pick_word(), pick_word(), 16'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == PHASE_ITEMS / 2) begin
          // hold commands until the output has caught up
          cmd_ch.valid <= 1'b0;
          drain_bytes();
        end
        send_command(random_row());
      end
      cmd_ch.valid <= 1'b0;
      drain_bytes();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** modbus_drive_command_framer_top: PASSED **");
    end else begin
      $display("** modbus_drive_command_framer_top: FAILED **");
    end
    $finish;
  end

endmodule
